@@ hdl/ramr_pkg.sv @@
// Shared types and constants for the rational add/multiply/reduce unit.
`timescale 1ns / 1ps

package ramr_pkg;

  // Operation codes carried on the input tuser
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  // Multiplier step selects
  localparam logic [1:0] MSEL_T1 = 2'd0;
  localparam logic [1:0] MSEL_T2 = 2'd1;
  localparam logic [1:0] MSEL_DEN = 2'd2;

  // Field width on the ports
  localparam int FIELD_W = 32;
  localparam int DEN_W = 31;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       gcd_step;
    logic       g_shift;
    logic       div_step;
    logic       out_load;
  } ramr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic gcd_done;
  } ramr_sts_t;

endpackage

@@ hdl/ramr_ctrl.sv @@
// Controller state machine that sequences multiply, gcd and divide steps.
`timescale 1ns / 1ps

module ramr_ctrl #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ramr_pkg::ramr_sts_t sts,
  output ramr_pkg::ramr_cmd_t cmd
);

  localparam int DW = 2 * VALUE_WIDTH;
  localparam int CW = $clog2(DW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_SHIFT,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt_r[1:0];
        if (cnt_r[1:0] == ramr_pkg::MSEL_DEN) begin
          state_nxt = ST_COMB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = ST_GCD;
      end
      ST_GCD: begin
        if (sts.gcd_done) begin
          state_nxt = ST_SHIFT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd.g_shift = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/ramr_dp.sv @@
// Datapath: operand magnitudes, shared multiplier, binary gcd, dividers, saturation.
`timescale 1ns / 1ps

module ramr_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  ramr_pkg::ramr_cmd_t                 cmd,
  input  logic                                operation,
  input  logic [ramr_pkg::FIELD_W-1:0]        a_num,
  input  logic [ramr_pkg::FIELD_W-1:0]        a_den,
  input  logic [ramr_pkg::FIELD_W-1:0]        b_num,
  input  logic [ramr_pkg::FIELD_W-1:0]        b_den,
  output ramr_pkg::ramr_sts_t                 sts,
  output logic signed [ramr_pkg::FIELD_W-1:0] res_num,
  output logic [ramr_pkg::DEN_W-1:0]          res_den,
  output logic                                overflow
);

  localparam int W  = VALUE_WIDTH;
  localparam int DW = 2 * W;
  localparam int KW = $clog2(DW + 1);
  localparam logic [DW-1:0] LIM = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};

  // Operand magnitudes and signs
  logic [W-1:0] an_raw, ad_raw, bn_raw, bd_raw;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic         an_neg, ad_neg, bn_neg, bd_neg;

  logic [W-1:0] am_r, ad_r, bm_r, bd_r;
  logic         an_s_r, ad_s_r, bn_s_r, bd_s_r, op_r;

  always_comb begin
    an_raw = a_num[W-1:0];
    ad_raw = a_den[W-1:0];
    bn_raw = b_num[W-1:0];
    bd_raw = b_den[W-1:0];
    an_neg = an_raw[W-1];
    bn_neg = bn_raw[W-1];
    ad_neg = ad_raw[W-1];
    bd_neg = bd_raw[W-1];
    an_mag = an_neg ? (W'(0) - an_raw) : an_raw;
    bn_mag = bn_neg ? (W'(0) - bn_raw) : bn_raw;
    ad_mag = ad_neg ? (W'(0) - ad_raw) : ad_raw;
    bd_mag = bd_neg ? (W'(0) - bd_raw) : bd_raw;
    // Treat a zero denominator as one
    if (ad_raw == '0) ad_mag = W'(1);
    if (bd_raw == '0) bd_mag = W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      am_r   <= an_mag;
      ad_r   <= ad_mag;
      bm_r   <= bn_mag;
      bd_r   <= bd_mag;
      an_s_r <= an_neg;
      ad_s_r <= ad_neg;
      bn_s_r <= bn_neg;
      bd_s_r <= bd_neg;
      op_r   <= operation;
    end
  end

  // Shared multiplier, one product per step
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] prod;
  logic [DW-1:0] p0_r, p1_r, dm_r;

  always_comb begin
    unique case (cmd.mul_sel)
      ramr_pkg::MSEL_T1: begin
        mul_a = am_r;
        mul_b = (op_r == ramr_pkg::OP_MUL) ? bm_r : bd_r;
      end
      ramr_pkg::MSEL_T2: begin
        mul_a = bm_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
    prod = DW'(mul_a) * DW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        ramr_pkg::MSEL_T1: p0_r <= prod;
        ramr_pkg::MSEL_T2: p1_r <= prod;
        default:           dm_r <= prod;
      endcase
    end
  end

  // Combine terms into signed numerator magnitude
  logic [DW-1:0] nm;
  logic          ns, s1, s2;

  always_comb begin
    s1 = an_s_r ^ bd_s_r;
    s2 = bn_s_r ^ ad_s_r;
    if (op_r == ramr_pkg::OP_MUL) begin
      nm = p0_r;
      ns = an_s_r ^ bn_s_r;
    end else if (s1 == s2) begin
      nm = p0_r + p1_r;
      ns = s1;
    end else if (p0_r >= p1_r) begin
      nm = p0_r - p1_r;
      ns = s1;
    end else begin
      nm = p1_r - p0_r;
      ns = s2;
    end
    ns = (ns ^ ad_s_r ^ bd_s_r) & (nm != '0);
  end

  // Binary gcd, one step per cycle
  logic [DW-1:0] u_r, v_r, g_r, nm_r;
  logic [KW-1:0] k_r;
  logic          ns_r;

  assign sts.gcd_done = (u_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      u_r  <= nm;
      v_r  <= dm_r;
      k_r  <= '0;
      nm_r <= nm;
      ns_r <= ns;
    end else if (cmd.gcd_step) begin
      priority if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= (u_r - v_r) >> 1;
      end else begin
        v_r <= (v_r - u_r) >> 1;
      end
    end
  end

  // Restore common power of two into the gcd
  always_ff @(posedge clk) begin
    if (cmd.g_shift) begin
      g_r <= v_r << k_r;
    end
  end

  // Two restoring dividers run side by side
  logic [DW:0]   rn_r, rd_r, shn, shd;
  logic [DW-1:0] qn_r, qd_r;
  logic          gen, ged;

  always_comb begin
    shn = {rn_r[DW-1:0], qn_r[DW-1]};
    shd = {rd_r[DW-1:0], qd_r[DW-1]};
    gen = (shn >= {1'b0, g_r});
    ged = (shd >= {1'b0, g_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.g_shift) begin
      rn_r <= '0;
      rd_r <= '0;
      qn_r <= nm_r;
      qd_r <= dm_r;
    end else if (cmd.div_step) begin
      rn_r <= gen ? (shn - {1'b0, g_r}) : shn;
      rd_r <= ged ? (shd - {1'b0, g_r}) : shd;
      qn_r <= {qn_r[DW-2:0], gen};
      qd_r <= {qd_r[DW-2:0], ged};
    end
  end

  // Saturate and register the result
  logic [DW-1:0]       nsat, dsat;
  logic [W-1:0]        nmag_w;
  logic signed [W-1:0] num_w;
  logic                ovf;

  always_comb begin
    ovf    = (qn_r > LIM) || (qd_r > LIM);
    nsat   = (qn_r > LIM) ? LIM : qn_r;
    dsat   = (qd_r > LIM) ? LIM : qd_r;
    nmag_w = nsat[W-1:0];
    num_w  = ns_r ? $signed(W'(0) - nmag_w) : $signed(nmag_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num  <= ramr_pkg::FIELD_W'(num_w);
      res_den  <= ramr_pkg::DEN_W'(dsat[W-2:0]);
      overflow <= ovf;
    end
  end

endmodule

@@ hdl/rational_add_mul_reduce_unit.sv @@
// Top level of the rational add/multiply unit with gcd reduction.
`timescale 1ns / 1ps

// Adds or multiplies two fractions and returns the result in lowest terms.
// Input channel in_*: one request per accepted beat; in_tuser selects the
// operation (0 add, 1 multiply), in_tdata carries the four operands.
// A zero operand denominator is taken as one. The result carries the sign
// on the numerator with a positive denominator; zero reads 0/1.
// Output channel out_*: one result per request; overflow is set and the
// fields saturate when the reduced result exceeds the signed range.
// Sequence: 3 multiplier steps on one shared multiplier, a combine step,
// the binary gcd loop (one subtract/shift step per cycle until u reaches
// zero), a shift step that restores the common power of two, 2*VALUE_WIDTH
// divider steps and an output load. The gcd loop and the bit-serial
// dividers set the time from acceptance to out_tvalid.
// One request is processed at a time; in_tready is high while idle, also
// while a finished result waits in the output register.
// A stalled receiver holds out_tdata; a finished result then waits in the
// datapath, held by the controller, until the output register is free.
// Reset clears the controller and drops any request in flight.

module rational_add_mul_reduce_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic         in_tuser,   // operation[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // res_num[31:0], res_den[62:32], overflow[63]
);

  ramr_pkg::ramr_cmd_t cmd;
  ramr_pkg::ramr_sts_t sts;

  logic signed [ramr_pkg::FIELD_W-1:0] res_num;
  logic [ramr_pkg::DEN_W-1:0]          res_den;
  logic                                overflow;

  ramr_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ramr_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .operation(in_tuser),
    .a_num    (in_tdata[31:0]),
    .a_den    (in_tdata[63:32]),
    .b_num    (in_tdata[95:64]),
    .b_den    (in_tdata[127:96]),
    .sts      (sts),
    .res_num  (res_num),
    .res_den  (res_den),
    .overflow (overflow)
  );

  assign out_tdata = {overflow, res_den, res_num};

`ifndef SYNTH
  // Denominator of a result is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[62:32] != 31'd0))
    else $error("result denominator is zero");

  // Zero result reads 0/1 without overflow
  a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[31:0] == 32'd0)) |->
      ((out_tdata[62:32] == 31'd1) && !out_tdata[63]))
    else $error("zero result not in 0/1 form");

  // No new request is taken while the datapath is busy with one
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");
`endif

endmodule
